FILE: design/sslr_pkg.sv
// ----------------------------------------------------------------------------
// sslr_pkg - servo slew ramp planner definitions
// Action codes, field widths, reset values and the limit clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package sslr_pkg;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned IDX_W   = 2;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned INITIAL_STEP_MS_DEF = 30;
  localparam int unsigned MIN_STEP_TIME_DEF   = 30;
  localparam int unsigned MIN_STEP_TIME_MAX   = 1000;

  // divider: dividend holds a time plus a carry, divisor holds the largest minimum interval
  localparam int unsigned DVD_W = TIME_W + 1;
  localparam int unsigned DVS_W = $clog2(MIN_STEP_TIME_MAX + 1);
  localparam int unsigned CNT_W = $clog2(DVD_W);

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [TIME_W-1:0]  ms_t;

  localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MOVE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STOP = 2'd3;

  localparam logic [IDX_W-1:0] REG_ANGLE_FLOOR   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ANGLE_CEILING = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP_FLOOR    = 2'd2;
  localparam logic [IDX_W-1:0] REG_STEP_CEILING  = 2'd3;

  localparam angle_t ANGLE_FLOOR_RST   = 8'd0;
  localparam angle_t ANGLE_CEILING_RST = 8'd180;
  localparam angle_t STEP_FLOOR_RST    = 8'd1;
  localparam angle_t STEP_CEILING_RST  = 8'd180;
  localparam angle_t POSITION_RST      = 8'd90;
  localparam angle_t LAST_WRITTEN_RST  = 8'd0;

  // ceiling test wins over the floor test
  function automatic angle_t clamp_limits(input angle_t v, input angle_t lo, input angle_t hi);
    angle_t r;
    if (v >= hi) begin
      r = hi;
    end else if (v <= lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/servo_slew_ramp_planner.sv
// ----------------------------------------------------------------------------
// servo_slew_ramp_planner - servo slew-rate limiter with timed-move planning
// Ticks step the angle toward the target; set, move and stop commands update
// the target (set and move also the step); timed moves are planned with a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   direction  signals                           transaction
//  s_*       in         s_tvalid s_tready s_tdata s_tuser one command
//  m_*       out        m_tvalid m_tready m_tdata         one result
//  cfg_*     in         cfg_we cfg_index cfg_data         one register write
//
//  Tick, set-angle and stop: the result is valid in the cycle after acceptance.
//  Timed move: plan and compare states, then per serial division a divide state
//  (17 quotient bits) and a post step; none for a move of one degree or less,
//  one for a slow move, two for a fast one; the finish state waits for the output.
//  Reset (rst, synchronous) restores registers and servo state at once.
//  A pending result holds m_tdata; a new command waits until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_ramp_planner #(
  parameter int unsigned INITIAL_STEP_MS = sslr_pkg::INITIAL_STEP_MS_DEF,
  parameter int unsigned MIN_STEP_TIME   = sslr_pkg::MIN_STEP_TIME_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // [7:0] target_angle, [15:8] speed_request, [31:16] move_time_ms
  input  wire logic [sslr_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] action
  input  wire logic [sslr_pkg::ACT_W-1:0]       s_tuser,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // [7:0] servo_angle, [8] write_strobe, [9] at_target, [25:10] step_interval_ms
  output      logic [sslr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [sslr_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [sslr_pkg::ANGLE_W-1:0]     cfg_data
);

  import sslr_pkg::*;

  localparam int unsigned PROD_W = DVS_W + ANGLE_W;
  localparam int unsigned PAD_W  = OUT_DATA_W - ANGLE_W - 2 - TIME_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PLAN = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [1:0] MODE_INTERVAL = 2'd0;
  localparam logic [1:0] MODE_COUNT    = 2'd1;
  localparam logic [1:0] MODE_STEP     = 2'd2;

  logic [2:0] state;
  logic [1:0] mode;

  angle_t angle_floor, angle_ceiling, step_floor, step_ceiling;
  angle_t current_position, target_position, last_written, step_size;
  ms_t    tick_interval;

  ms_t              t_reg;
  angle_t           span;
  logic [PROD_W-1:0] prod;

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W+1:0] trial;
  logic             qbit;
  logic [DVS_W-1:0] rem_next;
  angle_t           n_q;
  logic [DVS_W-1:0] sum_step;

  angle_t out_angle;
  logic   out_strobe;
  logic   out_at;
  ms_t    out_interval;

  angle_t in_angle, in_speed, new_target, tick_pos;
  ms_t    in_time;
  logic   accept;
  logic   out_free;
  logic   result_load;

  assign in_angle = s_tdata[7:0];
  assign in_speed = s_tdata[15:8];
  assign in_time  = s_tdata[31:16];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{PAD_W{1'b0}}, out_interval, out_at, out_strobe, out_angle};

  assign result_load = (accept && (s_tuser != ACT_MOVE)) || ((state == ST_FIN) && out_free);

  assign new_target = clamp_limits(in_angle, angle_floor, angle_ceiling);

  always_comb begin
    tick_pos = current_position;
    if (target_position > current_position) begin
      tick_pos = ((target_position - current_position) <= step_size) ? target_position
               : current_position + step_size;
    end else if (target_position < current_position) begin
      tick_pos = ((current_position - target_position) <= step_size) ? target_position
               : current_position - step_size;
    end
  end

  always_comb begin
    trial    = {1'b0, rem, dvd[DVD_W-1]} - {2'b00, dvs};
    qbit     = !trial[DVS_W+1];
    rem_next = qbit ? trial[DVS_W-1:0] : {rem[DVS_W-2:0], dvd[DVD_W-1]};
    n_q      = (dvd == '0) ? 8'd1 : dvd[ANGLE_W-1:0];
    sum_step = {{(DVS_W-ANGLE_W-1){1'b0}}, span, 1'b0} + {{(DVS_W-ANGLE_W){1'b0}}, n_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_floor   <= ANGLE_FLOOR_RST;
      angle_ceiling <= ANGLE_CEILING_RST;
      step_floor    <= STEP_FLOOR_RST;
      step_ceiling  <= STEP_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_FLOOR:   angle_floor   <= cfg_data;
        REG_ANGLE_CEILING: angle_ceiling <= cfg_data;
        REG_STEP_FLOOR:    step_floor    <= cfg_data;
        REG_STEP_CEILING:  step_ceiling  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      current_position <= POSITION_RST;
      target_position  <= POSITION_RST;
      last_written     <= LAST_WRITTEN_RST;
      step_size        <= STEP_FLOOR_RST;
      tick_interval    <= TIME_W'(INITIAL_STEP_MS);
      cnt              <= '0;
      mode             <= MODE_INTERVAL;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            out_interval <= tick_interval;
            case (s_tuser)
              ACT_TICK: begin
                current_position <= tick_pos;
                last_written     <= tick_pos;
                out_angle        <= tick_pos;
                out_strobe       <= (last_written != tick_pos);
                out_at           <= (tick_pos == target_position);
              end
              ACT_SET: begin
                target_position <= new_target;
                step_size       <= clamp_limits(in_speed, step_floor, step_ceiling);
                out_angle       <= current_position;
                out_strobe      <= 1'b0;
                out_at          <= (last_written == new_target);
              end
              ACT_MOVE: begin
                target_position <= new_target;
                t_reg           <= in_time;
                state           <= ST_PLAN;
              end
              default: begin
                target_position <= current_position;
                out_angle       <= current_position;
                out_strobe      <= 1'b0;
                out_at          <= (last_written == current_position);
              end
            endcase
          end
        end
        ST_PLAN: begin
          if (target_position >= last_written) begin
            span <= target_position - last_written;
            prod <= PROD_W'(DVS_W'(MIN_STEP_TIME)) * PROD_W'(target_position - last_written);
          end else begin
            span <= last_written - target_position;
            prod <= PROD_W'(DVS_W'(MIN_STEP_TIME)) * PROD_W'(last_written - target_position);
          end
          state <= ST_CMP;
        end
        ST_CMP: begin
          rem <= '0;
          cnt <= CNT_W'(DVD_W - 1);
          if (span <= 8'd1) begin
            tick_interval <= t_reg;
            step_size     <= span;
            state         <= ST_FIN;
          end else if (PROD_W'(t_reg) >= prod) begin
            dvd   <= DVD_W'(t_reg);
            dvs   <= DVS_W'(span);
            mode  <= MODE_INTERVAL;
            state <= ST_DIV;
          end else begin
            dvd   <= DVD_W'(t_reg) + DVD_W'(MIN_STEP_TIME - 1);
            dvs   <= DVS_W'(MIN_STEP_TIME);
            mode  <= MODE_COUNT;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd <= {dvd[DVD_W-2:0], qbit};
          rem <= rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          case (mode)
            MODE_INTERVAL: begin
              tick_interval <= dvd[TIME_W-1:0];
              step_size     <= 8'd1;
              state         <= ST_FIN;
            end
            MODE_COUNT: begin
              dvd   <= DVD_W'(sum_step);
              dvs   <= {{(DVS_W-ANGLE_W-1){1'b0}}, n_q, 1'b0};
              rem   <= '0;
              cnt   <= CNT_W'(DVD_W - 1);
              mode  <= MODE_STEP;
              state <= ST_DIV;
            end
            default: begin
              tick_interval <= TIME_W'(MIN_STEP_TIME);
              step_size     <= dvd[ANGLE_W-1:0];
              state         <= ST_FIN;
            end
          endcase
        end
        ST_FIN: begin
          if (out_free) begin
            out_angle    <= current_position;
            out_strobe   <= 1'b0;
            out_at       <= (last_written == target_position);
            out_interval <= tick_interval;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_move_plans: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_MOVE) |=> (state == ST_PLAN && !s_tready))
    else $error("timed move did not enter planning");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser != ACT_MOVE) |=> m_tvalid)
    else $error("single-cycle command gave no result");

  a_strobe_angle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_strobe) |-> (out_angle == last_written))
    else $error("strobed angle differs from last written angle");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != '0) |=> (state == ST_DIV && cnt == $past(cnt) - 1'b1))
    else $error("divider count slipped");

endmodule

`default_nettype wire

FILE: dv/sslr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sslr_checker - result checker for the servo slew ramp planner
// Watches the command, result and register-write channels, keeps its own copy
// of the servo state and limits, predicts one result per accepted command and
// compares every accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sslr_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  // [7:0] target_angle, [15:8] speed_request, [31:16] move_time_ms
  input  wire logic [sslr_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] action
  input  wire logic [sslr_pkg::ACT_W-1:0]      s_tuser,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] servo_angle, [8] write_strobe, [9] at_target, [25:10] step_interval_ms
  input  wire logic [sslr_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [sslr_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [sslr_pkg::ANGLE_W-1:0]    cfg_data,
  output int                                   pending,
  output int                                   errors,
  output int                                   checked
);

  import sslr_pkg::*;

  localparam int unsigned MIN_INTERVAL = MIN_STEP_TIME_DEF;

  typedef struct packed {
    angle_t angle;
    logic   strobe;
    logic   at_target;
    ms_t    interval;
  } servo_result_t;

  angle_t angle_lo, angle_hi, step_lo, step_hi;
  angle_t pos, tgt, last_wr, step;
  ms_t    interval;

  servo_result_t result_q[$];

  function automatic angle_t limit_to(angle_t v, angle_t lo, angle_t hi);
    return (v >= hi) ? hi : ((v <= lo) ? lo : v);
  endfunction

  // interval and step for a timed move from the last written angle
  function automatic void plan_move(ms_t t);
    int unsigned span, n, ivl, stp;
    span = (tgt >= last_wr) ? 32'(tgt - last_wr) : 32'(last_wr - tgt);
    if (span <= 1) begin
      ivl = t;
      stp = span;
    end else if (t >= MIN_INTERVAL * span) begin
      ivl = t / span;
      stp = 1;
    end else begin
      n = (t + MIN_INTERVAL - 1) / MIN_INTERVAL;
      if (n == 0) n = 1;
      ivl = MIN_INTERVAL;
      stp = (2 * span + n) / (2 * n);
    end
    if (ivl > 65535) ivl = 65535;
    if (stp > 255) stp = 255;
    interval = ivl[TIME_W-1:0];
    step = stp[ANGLE_W-1:0];
  endfunction

  function automatic servo_result_t apply_command(logic [ACT_W-1:0] act, angle_t ang,
                                                  angle_t spd, ms_t t);
    servo_result_t r;
    logic moved;
    moved = 1'b0;
    case (act)
      ACT_TICK: begin
        if (tgt > pos) begin
          pos = (tgt - pos <= step) ? tgt : pos + step;
        end else if (tgt < pos) begin
          pos = (pos - tgt <= step) ? tgt : pos - step;
        end
        if (last_wr != pos) begin
          last_wr = pos;
          moved = 1'b1;
        end
      end
      ACT_SET: begin
        tgt = limit_to(ang, angle_lo, angle_hi);
        step = limit_to(spd, step_lo, step_hi);
      end
      ACT_MOVE: begin
        tgt = limit_to(ang, angle_lo, angle_hi);
        plan_move(t);
      end
      default: begin
        tgt = pos;
      end
    endcase
    r.angle = pos;
    r.strobe = moved;
    r.at_target = (last_wr == tgt);
    r.interval = interval;
    return r;
  endfunction

  task automatic note_field(string label, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    servo_result_t want, got;
    if (rst) begin
      angle_lo = ANGLE_FLOOR_RST;
      angle_hi = ANGLE_CEILING_RST;
      step_lo  = STEP_FLOOR_RST;
      step_hi  = STEP_CEILING_RST;
      pos      = POSITION_RST;
      tgt      = POSITION_RST;
      last_wr  = LAST_WRITTEN_RST;
      step     = STEP_FLOOR_RST;
      interval = ms_t'(INITIAL_STEP_MS_DEF);
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_FLOOR:   angle_lo = cfg_data;
          REG_ANGLE_CEILING: angle_hi = cfg_data;
          REG_STEP_FLOOR:    step_lo = cfg_data;
          default:           step_hi = cfg_data;
        endcase
      end
      if (s_tvalid && s_tready) begin
        result_q.push_back(apply_command(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                         s_tdata[31:16]));
      end
      if (m_tvalid && m_tready) begin
        got.angle = m_tdata[7:0];
        got.strobe = m_tdata[8];
        got.at_target = m_tdata[9];
        got.interval = m_tdata[25:10];
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with none expected, expected nothing, actual %h",
                   $time, m_tdata);
        end else begin
          want = result_q.pop_front();
          checked++;
          note_field("servo_angle", 32'(want.angle), 32'(got.angle));
          note_field("write_strobe", 32'(want.strobe), 32'(got.strobe));
          note_field("at_target", 32'(want.at_target), 32'(got.at_target));
          note_field("step_interval_ms", 32'(want.interval), 32'(got.interval));
        end
      end
    end
    pending = result_q.size();
  end

endmodule

`default_nettype wire

FILE: dv/tb_servo_slew_ramp_planner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_slew_ramp_planner - testbench for the servo slew ramp planner
// Drives directed and random set, timed-move, stop and tick commands under
// several limit settings and three handshake idling profiles; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_servo_slew_ramp_planner;

  import sslr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned BLOCK_ITEMS = 117;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [ACT_W-1:0]      s_tuser = ACT_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = REG_ANGLE_FLOOR;
  angle_t                cfg_data = '0;

  int          pending, errors, checked;
  int unsigned gap_pct = 8;
  int unsigned stall_pct = 54;
  int unsigned ticks_left = 0;
  int unsigned reg_writes = 0;
  int unsigned action_count[4] = '{0, 0, 0, 0};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  servo_slew_ramp_planner dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sslr_checker result_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors), .checked(checked)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send(logic [ACT_W-1:0] act, angle_t ang, angle_t spd, ms_t t);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {t, spd, ang};
    do @(posedge clk); while (!s_tready);
    action_count[act]++;
  endtask

  // hold until every expected result has arrived
  task automatic settle(int unsigned extra);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, angle_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_limits(angle_t a_lo, angle_t a_hi, angle_t s_lo, angle_t s_hi);
    settle(4);
    write_reg(REG_ANGLE_FLOOR, a_lo);
    write_reg(REG_ANGLE_CEILING, a_hi);
    write_reg(REG_STEP_FLOOR, s_lo);
    write_reg(REG_STEP_CEILING, s_hi);
  endtask

  // mostly a command followed by a run of ticks, with stray stops and ticks
  task automatic send_random();
    logic [ACT_W-1:0] act;
    angle_t           ang, spd;
    ms_t              t;
    int unsigned      roll;
    ang = angle_t'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 15) ang = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    spd = ($urandom_range(0, 99) < 40) ? angle_t'($urandom_range(0, 8))
                                       : angle_t'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       t = '0;
      1:       t = '1;
      2, 3:    t = ms_t'($urandom_range(0, 90));
      4, 5, 6: t = ms_t'($urandom_range(0, 3000));
      default: t = ms_t'($urandom_range(0, 65535));
    endcase
    roll = $urandom_range(0, 99);
    if (ticks_left > 0 && roll >= 5) begin
      act = ACT_TICK;
      ticks_left--;
    end else if (roll < 45) begin
      act = ACT_SET;
    end else if (roll < 80) begin
      act = ACT_MOVE;
    end else if (roll < 90) begin
      act = ACT_STOP;
    end else begin
      act = ACT_TICK;
    end
    if (act == ACT_SET || act == ACT_MOVE) ticks_left = $urandom_range(1, 12);
    send(act, ang, spd, t);
  endtask

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    angle_t a_lo, a_hi, s_lo, s_hi;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_TICK, 8'hff, 8'hff, 16'hffff);
    send(ACT_SET, 8'd255, 8'd255, 16'd0);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_SET, 8'd0, 8'd0, 16'hffff);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_STOP, 8'hff, 8'hff, 16'hffff);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_MOVE, 8'd0, 8'd0, 16'd0);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_MOVE, 8'd0, 8'd0, 16'hffff);
    send(ACT_MOVE, 8'd1, 8'd0, 16'd77);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_MOVE, 8'd180, 8'd0, 16'hffff);
    send(ACT_MOVE, 8'd180, 8'd0, 16'd29);
    send(ACT_MOVE, 8'd180, 8'd0, 16'd31);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    send(ACT_SET, 8'd128, 8'd127, 16'd30);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);
    // floor above ceiling: the ceiling wins
    set_limits(8'd200, 8'd50, 8'd9, 8'd3);
    send(ACT_SET, 8'd100, 8'd5, 16'd0);
    send(ACT_MOVE, 8'd255, 8'd0, 16'd300);
    send(ACT_TICK, 8'd0, 8'd0, 16'd0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          gap_pct = 8;
          stall_pct = 54;
        end
        1: begin
          gap_pct = 54;
          stall_pct = 8;
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int c = 0; c < 4; c++) begin
        case (c)
          0: begin
            a_lo = ANGLE_FLOOR_RST;
            a_hi = ANGLE_CEILING_RST;
            s_lo = STEP_FLOOR_RST;
            s_hi = STEP_CEILING_RST;
          end
          1: begin
            a_lo = 8'd0;
            a_hi = 8'd255;
            s_lo = 8'd0;
            s_hi = 8'd255;
          end
          2: begin
            a_lo = (p == 0) ? 8'd255 : angle_t'($urandom_range(128, 255));
            a_hi = (p == 0) ? 8'd0 : angle_t'($urandom_range(0, 127));
            s_lo = (p == 0) ? 8'd255 : angle_t'($urandom_range(100, 255));
            s_hi = (p == 0) ? 8'd0 : angle_t'($urandom_range(0, 99));
          end
          default: begin
            a_lo = angle_t'($urandom_range(0, 120));
            a_hi = angle_t'($urandom_range(100, 255));
            s_lo = angle_t'($urandom_range(0, 20));
            s_hi = angle_t'($urandom_range(0, 255));
          end
        endcase
        set_limits(a_lo, a_hi, s_lo, s_hi);
        for (int k = 0; k < BLOCK_ITEMS; k++) begin
          send_random();
          if (k == BLOCK_ITEMS / 2) settle(0);
        end
      end
    end

    settle(48);
    $display("run: %0d ticks, %0d set-angle, %0d timed moves, %0d stops, %0d register writes",
             action_count[ACT_TICK], action_count[ACT_SET], action_count[ACT_MOVE],
             action_count[ACT_STOP], reg_writes);
    $display("run: %0d results compared across three idling profiles", checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/sslr_pkg.sv
design/servo_slew_ramp_planner.sv
dv/sslr_checker.sv
dv/tb_servo_slew_ramp_planner.sv
